// ===== design/mws_pkg.sv =====
// Shared types, codes and sizes for the minimum-window subsequence block.
package mws_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int TEXT_MAX    = 65536;

  // Position widths follow from the text capacity.
  localparam int POS_W   = $clog2(TEXT_MAX + 1);
  localparam int START_W = $clog2(TEXT_MAX);
  localparam int LEN_W   = START_W + 1;

  localparam logic [1:0] OP_PATTERN = 2'd0;
  localparam logic [1:0] OP_TEXT    = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  typedef logic [15:0] win_start_t;
  typedef logic [16:0] win_len_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic       found;
    win_start_t window_start;
    win_len_t   window_length;
    logic       overflow;
  } out_item_t;

  // Chain signals handed from one cell to the next.
  typedef struct packed {
    logic               active;
    logic               valid;
    logic [START_W-1:0] start;
  } link_t;

  // Broadcast controls for every cell.
  typedef struct packed {
    logic       clear;
    logic       load;
    logic       scan;
    logic [7:0] symbol;
  } ctl_t;

  // Registered item between the cell row and the best-window tracker.
  typedef struct packed {
    logic               valid;
    logic               is_end;
    logic               hit;
    logic [START_W-1:0] start;
    logic [START_W-1:0] pos;
    logic               nonempty;
    logic               ovf;
  } stage_t;

endpackage

// ===== design/min_window_subsequence_top.sv =====
// Top level of the minimum-window subsequence block: cell row, pipeline and tracker.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  in_data  (op, symbol)
//   out_     out  out_valid/ out_stall out_data (found, window_start,
//                                               window_length, overflow)
//
// One item is taken per cycle while in_stall is low; every cell of the row updates in the
// cycle of the transfer. A result goes from its end-of-text transfer through the hit
// register, then through the best-window compare into the
// output register. Reset (rst_n low, synchronous) empties the pattern row and the
// scan state at once. in_stall rises only while an end-of-text item waits behind
// a result that out_stall is holding.
module min_window_subsequence_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mws_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mws_pkg::out_item_t out_data
);

  localparam int N = mws_pkg::PATTERN_MAX;

  logic                        accept;
  logic                        blocked;
  logic                        is_pat;
  logic                        is_text;
  logic                        is_end;
  logic                        pat_full;
  logic                        text_full;
  logic [mws_pkg::POS_W-1:0]   text_pos_r;
  logic                        ovf_r;
  mws_pkg::ctl_t               ctl;
  mws_pkg::link_t              link [0:N];
  logic [N-1:0]                next_active;
  logic [N-1:0]                hit;
  logic                        hit_any;
  logic [mws_pkg::START_W-1:0] hit_start;
  mws_pkg::stage_t             stage_r;

  assign in_stall = blocked;
  assign accept   = in_valid & ~in_stall;

  assign is_pat  = accept & (in_data.op == mws_pkg::OP_PATTERN);
  assign is_text = accept & (in_data.op == mws_pkg::OP_TEXT);
  assign is_end  = accept & (in_data.op == mws_pkg::OP_END);

  // The row is full once its far cell holds a byte.
  assign pat_full  = link[N].active;
  assign text_full = (text_pos_r == mws_pkg::POS_W'(mws_pkg::TEXT_MAX));

  // Drop pattern bytes once any text byte of the run has arrived.
  assign ctl.clear  = is_end;
  assign ctl.load   = is_pat & (text_pos_r == '0) & ~pat_full;
  assign ctl.scan   = is_text & ~text_full;
  assign ctl.symbol = in_data.symbol;

  // The head of the chain looks like a matched, always-valid prefix that
  // starts at the current text position.
  assign link[0].active = 1'b1;
  assign link[0].valid  = 1'b1;
  assign link[0].start  = text_pos_r[mws_pkg::START_W-1:0];

  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == N - 1) begin : g_tail
      assign next_active[k] = 1'b0;
    end else begin : g_mid
      assign next_active[k] = link[k+2].active;
    end
    mws_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .prev        (link[k]),
      .next_active (next_active[k]),
      .link_out    (link[k+1]),
      .hit         (hit[k])
    );
  end

  // At most one cell fires, so an AND-OR picks its window start.
  always_comb begin
    hit_any   = 1'b0;
    hit_start = '0;
    for (int k = 0; k < N; k++) begin
      hit_any   = hit_any | hit[k];
      hit_start = hit_start | ({mws_pkg::START_W{hit[k]}} & link[k].start);
    end
  end

  // Advance the text position and track capacity overflow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_pos_r <= '0;
      ovf_r      <= 1'b0;
    end else if (is_end) begin
      text_pos_r <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (ctl.scan) text_pos_r <= text_pos_r + mws_pkg::POS_W'(1);
      if ((is_pat && text_pos_r == '0 && pat_full) || (is_text && text_full)) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Hit register: hold while the tracker is blocked, otherwise take the
  // transfer of this cycle (or a bubble).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (!blocked) begin
      stage_r.valid <= ctl.scan | is_end;
    end
    if (!blocked) begin
      stage_r.is_end   <= is_end;
      stage_r.hit      <= hit_any;
      stage_r.start    <= hit_start;
      stage_r.pos      <= text_pos_r[mws_pkg::START_W-1:0];
      stage_r.nonempty <= link[1].active;
      stage_r.ovf      <= ovf_r;
    end
  end

  mws_best u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage_r),
    .out_stall (out_stall),
    .blocked   (blocked),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Only the last pattern cell may complete a window.
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit))
    else $error("more than one cell completed the pattern");

  // Input is held back only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && stage_r.valid && stage_r.is_end))
    else $error("input stalled without a waiting result");

  // An end-of-text transfer empties the pattern row and the scan position.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_end |=> (!link[1].active && text_pos_r == '0))
    else $error("state not cleared after end of text");

  // Text position never passes capacity.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    text_pos_r <= mws_pkg::POS_W'(mws_pkg::TEXT_MAX))
    else $error("text position beyond capacity");

endmodule

// ===== design/mws_cell.sv =====
// One pattern cell: a pattern byte and the latest window start for its prefix.
module mws_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  mws_pkg::ctl_t  ctl,
  input  mws_pkg::link_t prev,
  input  logic           next_active,
  output mws_pkg::link_t link_out,
  output logic           hit
);

  logic                        active_r;
  logic                        valid_r;
  logic [7:0]                  byte_r;
  logic [mws_pkg::START_W-1:0] start_r;
  logic                        take;

  // Extend the prefix held by the left neighbor when this byte matches.
  assign take = ctl.scan & active_r & (byte_r == ctl.symbol) & prev.valid;
  // Only the last active cell completes the whole pattern.
  assign hit  = take & ~next_active;

  assign link_out.active = active_r;
  assign link_out.valid  = valid_r;
  assign link_out.start  = start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else if (ctl.clear) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else if (ctl.load && !active_r && prev.active) begin
      active_r <= 1'b1;
      valid_r  <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && !active_r && prev.active) begin
      byte_r  <= ctl.symbol;
      start_r <= '0;
    end else if (take) begin
      start_r <= prev.start;
    end
  end

endmodule

// ===== design/mws_best.sv =====
// Best-window tracker and output register.
module mws_best (
  input  logic               clk,
  input  logic               rst_n,
  input  mws_pkg::stage_t    stage,
  input  logic               out_stall,
  output logic               blocked,
  output logic               out_valid,
  output mws_pkg::out_item_t out_data
);

  logic                        best_found_r;
  logic [mws_pkg::START_W-1:0] best_start_r;
  logic [mws_pkg::LEN_W-1:0]   best_len_r;
  logic                        out_valid_r;
  mws_pkg::out_item_t          out_data_r;
  logic [mws_pkg::LEN_W-1:0]   len;
  logic                        take;
  logic                        emit;
  logic                        found;

  assign len = {1'b0, stage.pos} - {1'b0, stage.start} + mws_pkg::LEN_W'(1);

  // Hold an end item while the previous result still waits.
  assign blocked = stage.valid & stage.is_end & out_valid_r & out_stall;
  assign take    = stage.valid & ~blocked;
  assign emit    = take & stage.is_end;
  assign found   = best_found_r & stage.nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r  <= 1'b1;
        best_found_r <= 1'b0;
      end else begin
        if (!out_stall) out_valid_r <= 1'b0;
        if (take && stage.hit && (!best_found_r || len < best_len_r)) begin
          best_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.found         <= found;
      out_data_r.window_start  <= found ? mws_pkg::win_start_t'(best_start_r) : '0;
      out_data_r.window_length <= found ? mws_pkg::win_len_t'(best_len_r) : '0;
      out_data_r.overflow      <= stage.ovf;
    end
    if (take && !stage.is_end && stage.hit && (!best_found_r || len < best_len_r)) begin
      best_start_r <= stage.start;
      best_len_r   <= len;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/tb_min_window_subsequence_top.sv =====
// Self-checking testbench for the minimum-window subsequence block.
module tb_min_window_subsequence_top;

  // Op code 3 is not assigned; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CLK_PERIOD = 10;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PRINT_CAP = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 465;
  localparam int MIN_RANDOM_RUNS = 20;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mws_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mws_pkg::out_item_t out_data;

  // Handshake between the sender and the receiver for the long hold-off.
  bit squeeze_req = 1'b0;
  bit squeeze_done = 1'b0;

  // Predicts each window answer and compares it with what the block sends.
  class window_scoreboard;
    logic [7:0]  pat_sym [mws_pkg::PATTERN_MAX];
    logic [5:0]  pat_count;
    logic [15:0] cell_start [mws_pkg::PATTERN_MAX];
    bit          cell_live [mws_pkg::PATTERN_MAX];
    logic [16:0] text_pos;
    logic [15:0] best_start;
    logic [16:0] best_len;
    bit          best_hit;
    bit          ovf_seen;
    mws_pkg::out_item_t answer_q[$];
    int          errors;
    int          answers;
    int          items;

    function new();
      clear_run();
      errors = 0;
      answers = 0;
      items = 0;
    endfunction

    function void clear_run();
      for (int k = 0; k < mws_pkg::PATTERN_MAX; k++) begin
        pat_sym[k] = '0;
        cell_start[k] = '0;
        cell_live[k] = 1'b0;
      end
      pat_count = '0;
      text_pos = '0;
      best_start = '0;
      best_len = '0;
      best_hit = 1'b0;
      ovf_seen = 1'b0;
    endfunction

    // Cells update from high to low so each reads its neighbor's old value.
    function void scan_byte(logic [7:0] c);
      bit          ended;
      logic [16:0] len;
      ended = 1'b0;
      for (int k = int'(pat_count) - 1; k >= 0; k--) begin
        if (pat_sym[k] != c) continue;
        if (k == 0) begin
          cell_start[0] = text_pos[15:0];
          cell_live[0] = 1'b1;
        end else if (cell_live[k-1]) begin
          cell_start[k] = cell_start[k-1];
          cell_live[k] = 1'b1;
        end else begin
          continue;
        end
        if (k == int'(pat_count) - 1) ended = 1'b1;
      end
      if (ended) begin
        len = text_pos - {1'b0, cell_start[pat_count-1]} + 17'd1;
        if (!best_hit || len < best_len) begin
          best_hit = 1'b1;
          best_start = cell_start[pat_count-1];
          best_len = len;
        end
      end
      text_pos = text_pos + 17'd1;
    endfunction

    function void note_item(mws_pkg::in_item_t it);
      mws_pkg::out_item_t ans;
      items++;
      case (it.op)
        mws_pkg::OP_PATTERN: begin
          // Pattern bytes after any text of this run are dropped silently.
          if (text_pos == 0) begin
            if (pat_count >= mws_pkg::PATTERN_MAX) begin
              ovf_seen = 1'b1;
            end else begin
              pat_sym[pat_count] = it.symbol;
              cell_live[pat_count] = 1'b0;
              cell_start[pat_count] = '0;
              pat_count = pat_count + 6'd1;
            end
          end
        end
        mws_pkg::OP_TEXT: begin
          if (text_pos >= mws_pkg::TEXT_MAX) ovf_seen = 1'b1;
          else scan_byte(it.symbol);
        end
        mws_pkg::OP_END: begin
          ans.found = best_hit && (pat_count != 0);
          ans.window_start = ans.found ? best_start : '0;
          ans.window_length = ans.found ? best_len : '0;
          ans.overflow = ovf_seen;
          answer_q = {answer_q, ans};
          clear_run();
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_answer(mws_pkg::out_item_t got);
      mws_pkg::out_item_t want;
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", got));
        return;
      end
      want = answer_q.pop_front();
      answers++;
      if (got.found !== want.found)
        report_mismatch($sformatf("result %0d found %b, want %b",
                                  answers, got.found, want.found));
      if (got.window_start !== want.window_start)
        report_mismatch($sformatf("result %0d window_start %0d, want %0d",
                                  answers, got.window_start, want.window_start));
      if (got.window_length !== want.window_length)
        report_mismatch($sformatf("result %0d window_length %0d, want %0d",
                                  answers, got.window_length, want.window_length));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("result %0d overflow %b, want %b",
                                  answers, got.overflow, want.overflow));
    endtask

    function int pending();
      return answer_q.size();
    endfunction
  endclass

  window_scoreboard board;

  min_window_subsequence_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial board = new();

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hold reset low from time zero, then release it for good.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Safety net: a hung handshake ends the run here.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results outstanding", board.pending());
    $display("min_window_subsequence_top: mismatch");
    $finish;
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) board.check_answer(out_data);
  end

  // Receiver: pick a stall pattern for a random stretch, then switch. Once the
  // sender asks, hold off for a long fixed stretch so the block backs up.
  initial begin : receiver
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_stall <= 1'b1;
        for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clk);
        out_stall <= 1'b0;
        squeeze_done = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        if (mode == 0) out_stall <= 1'b0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 1) == 1);
        else if (mode == 2) out_stall <= ($urandom_range(0, 7) == 0);
        else out_stall <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  bit gaps_on = 1'b1;
  int burst_left = 0;
  int real_items = 0;

  // Drop valid and scramble the payload while the sender idles.
  task automatic idle_for(int n);
    in_valid <= 1'b0;
    in_data <= mws_pkg::in_item_t'($urandom_range(0, 1023));
    repeat (n) @(posedge clk);
  endtask

  // Offer one item and hold it until the transfer happens. Returns at the
  // edge of the transfer with valid still high, so back-to-back items keep it up.
  task automatic offer(logic [1:0] op, logic [7:0] sym);
    mws_pkg::in_item_t it;
    it.op = op;
    it.symbol = sym;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 7));
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    if (op != OP_UNUSED) real_items++;
  endtask

  // Pause the sender until every predicted result is in, plus pipeline slack.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic text_span(logic [7:0] sym, int count);
    repeat (count) offer(mws_pkg::OP_TEXT, sym);
  endtask

  // Mostly a small alphabet around the run's base byte, so matches are common.
  function automatic logic [7:0] run_symbol(logic [7:0] base, int spread);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return base ^ 8'($urandom_range(0, spread));
  endfunction

  // One pattern/text/end run with random content and a little noise mixed in.
  task automatic random_run();
    logic [7:0] base;
    int plen;
    int tlen;
    int spread;
    int r;
    base = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 19);
    if (r == 0) plen = 0;
    else if (r == 1) plen = $urandom_range(30, 34);
    else plen = $urandom_range(1, 4);
    spread = (plen > 20) ? 1 : 3;
    tlen = (plen > 20) ? $urandom_range(30, 70) : $urandom_range(0, 24);
    for (int j = 0; j < plen; j++) offer(mws_pkg::OP_PATTERN, run_symbol(base, spread));
    for (int j = 0; j < tlen; j++) begin
      if ($urandom_range(0, 39) == 0)
        offer(mws_pkg::OP_PATTERN, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 29) == 0) offer(OP_UNUSED, 8'($urandom_range(0, 255)));
      offer(mws_pkg::OP_TEXT, run_symbol(base, spread));
    end
    // Now and then skip the end so the next run's pattern lands after text.
    if ($urandom_range(0, 19) != 0) offer(mws_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int runs;
    int start_items;
    logic [7:0] s;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Directed: empty pattern reports not found.
    offer(mws_pkg::OP_END, 8'hFF);
    // Extreme bytes, an unused op, a pattern byte after text, a shorter later window.
    offer(mws_pkg::OP_PATTERN, 8'h00);
    offer(mws_pkg::OP_PATTERN, 8'hFF);
    offer(OP_UNUSED, 8'hFF);
    offer(mws_pkg::OP_TEXT, 8'h00);
    offer(mws_pkg::OP_TEXT, 8'h11);
    offer(mws_pkg::OP_TEXT, 8'hFF);
    offer(mws_pkg::OP_PATTERN, 8'h77);
    offer(mws_pkg::OP_TEXT, 8'h00);
    offer(mws_pkg::OP_TEXT, 8'hFF);
    offer(mws_pkg::OP_END, 8'h00);
    // No match in the text.
    offer(mws_pkg::OP_PATTERN, 8'h5A);
    offer(mws_pkg::OP_TEXT, 8'hA5);
    offer(mws_pkg::OP_END, 8'h00);
    // Two windows of equal length: the earlier ending one wins.
    offer(mws_pkg::OP_PATTERN, 8'h61);
    offer(mws_pkg::OP_PATTERN, 8'h62);
    offer(mws_pkg::OP_TEXT, 8'h61);
    offer(mws_pkg::OP_TEXT, 8'h62);
    offer(mws_pkg::OP_TEXT, 8'h78);
    offer(mws_pkg::OP_TEXT, 8'h61);
    offer(mws_pkg::OP_TEXT, 8'h62);
    offer(mws_pkg::OP_END, 8'h00);
    drain_results();

    // Pattern full: the byte past capacity is dropped and flags overflow.
    repeat (mws_pkg::PATTERN_MAX + 1) offer(mws_pkg::OP_PATTERN, 8'hAA);
    text_span(8'hAA, mws_pkg::PATTERN_MAX + 1);
    offer(mws_pkg::OP_END, 8'h00);
    drain_results();

    // Long receiver hold-off while short runs keep coming: the block fills
    // and must stall its input without losing a transfer.
    squeeze_req = 1'b1;
    repeat (15) begin
      s = 8'($urandom_range(0, 255));
      offer(mws_pkg::OP_PATTERN, s);
      offer(mws_pkg::OP_TEXT, s);
      offer(mws_pkg::OP_END, 8'h00);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (!squeeze_done) @(posedge clk);
    drain_results();

    // Random runs, with bursty sending and a drain now and then.
    gaps_on = 1'b1;
    runs = 0;
    start_items = real_items;
    while ((real_items - start_items) < RANDOM_ITEMS || runs < MIN_RANDOM_RUNS) begin
      random_run();
      runs++;
      if ($urandom_range(0, 9) == 0) drain_results();
    end
    // The final run may have skipped its end; close it out.
    offer(mws_pkg::OP_END, 8'h00);
    drain_results();
    repeat (10) @(posedge clk);

    $display("covered %0d input transfers and %0d results: directed cases, a full pattern,",
             board.items, board.answers);
    $display("a %0d-cycle receiver hold-off and %0d random runs", HOLD_CYCLES, runs);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("min_window_subsequence_top: match");
    end else begin
      $display("min_window_subsequence_top: mismatch");
    end
    $finish;
  end

endmodule
